@@ hw/rtl/malu_pkg.sv @@
package malu_pkg;

    localparam int XLEN     = 32;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int IMM_W    = 16;

    typedef enum logic [5:0] {
        OP_RTYPE = 6'd0,
        OP_ADDI  = 6'd8,
        OP_ADDIU = 6'd9,
        OP_SLTI  = 6'd10,
        OP_SLTIU = 6'd11
    } opcode_t;

    typedef enum logic [5:0] {
        FN_SLL  = 6'd0,
        FN_SRL  = 6'd2,
        FN_SRA  = 6'd3,
        FN_SLLV = 6'd4,
        FN_SRLV = 6'd6,
        FN_ADD  = 6'd32,
        FN_ADDU = 6'd33,
        FN_SUB  = 6'd34,
        FN_SUBU = 6'd35,
        FN_AND  = 6'd36,
        FN_OR   = 6'd37,
        FN_XOR  = 6'd38,
        FN_SLT  = 6'd42,
        FN_SLTU = 6'd43
    } funct_t;

    typedef struct packed {
        logic [5:0]        kind;
        logic [REG_AW-1:0] source_reg;
        logic [REG_AW-1:0] second_reg;
        logic [REG_AW-1:0] dest_reg;
        logic [4:0]        shift_amount;
        logic [5:0]        function_code;
        logic [IMM_W-1:0]  immediate;
    } req_t;

    typedef struct packed {
        logic              wrote;
        logic [REG_AW-1:0] written_reg;
        logic [XLEN-1:0]   written_value;
        logic              unsupported;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr_a;
        logic [REG_AW-1:0] addr_b;
    } rf_rd_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

endpackage

@@ hw/rtl/mips_alu_register_execute.sv @@
// an accepted word is registered into the execute stage, then into the rsp register
// throughput: one word per cycle while rsp_ready holds; register read, alu and write-back overlap
// register file is a ram with registered read; same-edge writes are forwarded
// reset clears all control state and marks every register as zero at once
// no clearing pass is needed after reset
module mips_alu_register_execute (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  malu_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output malu_pkg::rsp_t  rsp
);

    import malu_pkg::*;

    logic            s1_valid_reg;
    req_t            s1_item_reg;
    logic            rsp_valid_reg;
    rsp_t            rsp_reg;
    logic            s1_advance;
    logic            accept;
    rf_rd_t          rf_rd;
    rf_wr_t          rf_wr;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
    rsp_t            res;

    assign s1_advance = !rsp_valid_reg || rsp_ready;
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign accept     = req_valid && req_ready;

    assign rf_rd.en     = accept;
    assign rf_rd.addr_a = req.source_reg;
    assign rf_rd.addr_b = req.second_reg;

    malu_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rf_rd),
        .wr     (rf_wr),
        .data_a (op_a),
        .data_b (op_b)
    );

    malu_alu u_alu (
        .item (s1_item_reg),
        .a    (op_a),
        .b    (op_b),
        .res  (res)
    );

    // register zero is reported but never stored
    assign rf_wr.en   = s1_valid_reg && s1_advance && res.wrote && (res.written_reg != '0);
    assign rf_wr.addr = res.written_reg;
    assign rf_wr.data = res.written_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (s1_advance)
                rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= req;
        if (s1_valid_reg && s1_advance)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word did not enter execute stage");

    a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid && !rsp_ready) |=> s1_valid_reg)
        else $error("execute stage dropped a word under stall");

    a_s1_reaches_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=> rsp_valid)
        else $error("executed word not presented on rsp");

    a_unsupported_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.unsupported) |-> (!rsp.wrote && rsp.written_value == '0))
        else $error("unsupported word reports a write");
`endif

endmodule

@@ hw/rtl/malu_ram.sv @@
module malu_ram #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 32
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [DATA_WIDTH-1:0]         wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
    output logic [DATA_WIDTH-1:0]         rd_data_a,
    output logic [DATA_WIDTH-1:0]         rd_data_b
);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] q_a_reg;
    logic [DATA_WIDTH-1:0] q_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_a_reg <= mem_reg[rd_addr_a];
            q_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = q_a_reg;
    assign rd_data_b = q_b_reg;

endmodule

@@ hw/rtl/malu_regfile.sv @@
module malu_regfile (
    input  logic                    clk,
    input  logic                    rst_n,
    input  malu_pkg::rf_rd_t        rd,
    input  malu_pkg::rf_wr_t        wr,
    output logic [malu_pkg::XLEN-1:0] data_a,
    output logic [malu_pkg::XLEN-1:0] data_b
);

    import malu_pkg::*;

    logic [NUM_REGS-1:0] valid_reg;
    logic [REG_AW-1:0]   addr_a_reg;
    logic [REG_AW-1:0]   addr_b_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic                byp_valid_reg;
    logic [REG_AW-1:0]   byp_addr_reg;
    logic [XLEN-1:0]     byp_data_reg;
    logic [XLEN-1:0]     ram_a;
    logic [XLEN-1:0]     ram_b;

    malu_ram #(
        .DATA_WIDTH (XLEN),
        .DEPTH      (NUM_REGS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr.en),
        .wr_addr   (wr.addr),
        .wr_data   (wr.data),
        .rd_en     (rd.en),
        .rd_addr_a (rd.addr_a),
        .rd_addr_b (rd.addr_b),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
                byp_valid_reg      <= 1'b1;
            end
        end
    end

    // last write, covers a read issued on the same edge
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            byp_addr_reg <= wr.addr;
            byp_data_reg <= wr.data;
        end
        if (rd.en)
        begin
            addr_a_reg <= rd.addr_a;
            addr_b_reg <= rd.addr_b;
            vld_a_reg  <= valid_reg[rd.addr_a];
            vld_b_reg  <= valid_reg[rd.addr_b];
        end
    end

    always_comb
    begin
        if (addr_a_reg == '0)
            data_a = '0;
        else if (byp_valid_reg && byp_addr_reg == addr_a_reg)
            data_a = byp_data_reg;
        else if (vld_a_reg)
            data_a = ram_a;
        else
            data_a = '0;

        if (addr_b_reg == '0)
            data_b = '0;
        else if (byp_valid_reg && byp_addr_reg == addr_b_reg)
            data_b = byp_data_reg;
        else if (vld_b_reg)
            data_b = ram_b;
        else
            data_b = '0;
    end

endmodule

@@ hw/rtl/malu_alu.sv @@
module malu_alu (
    input  malu_pkg::req_t              item,
    input  logic [malu_pkg::XLEN-1:0]   a,
    input  logic [malu_pkg::XLEN-1:0]   b,
    output malu_pkg::rsp_t              res
);

    import malu_pkg::*;

    logic [XLEN-1:0]   imm;
    logic [XLEN-1:0]   val;
    logic [REG_AW-1:0] dst;
    logic              ok;

    assign imm = {{(XLEN-IMM_W){item.immediate[IMM_W-1]}}, item.immediate};

    always_comb
    begin
        val = '0;
        dst = item.second_reg;
        ok  = 1'b1;
        unique case (item.kind) inside
            OP_RTYPE:
            begin
                dst = item.dest_reg;
                unique case (item.function_code) inside
                    FN_ADD, FN_ADDU: val = a + b;
                    FN_SUB, FN_SUBU: val = a - b;
                    FN_AND:          val = a & b;
                    FN_OR:           val = a | b;
                    FN_XOR:          val = a ^ b;
                    FN_SLL:          val = b << item.shift_amount;
                    FN_SRL:          val = b >> item.shift_amount;
                    FN_SRA:          val = $unsigned($signed(b) >>> item.shift_amount);
                    FN_SLLV:         val = b << a[4:0];
                    FN_SRLV:         val = b >> a[4:0];
                    FN_SLT:          val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
                    FN_SLTU:         val = {{(XLEN-1){1'b0}}, a < b};
                    default:         ok = 1'b0;
                endcase
            end
            OP_ADDI, OP_ADDIU: val = a + imm;
            OP_SLTI:           val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm)};
            OP_SLTIU:          val = {{(XLEN-1){1'b0}}, a < imm};
            default:           ok = 1'b0;
        endcase

        res.wrote         = ok;
        res.written_reg   = ok ? dst : '0;
        res.written_value = ok ? val : '0;
        res.unsupported   = !ok;
    end

endmodule

@@ tb/malu_writeback_checker.sv @@
`timescale 1ns / 100ps

module malu_writeback_checker
    import malu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    logic [XLEN-1:0] gpr_shadow [NUM_REGS];
    rsp_t            expected_writebacks [$];

    function automatic rsp_t execute_alu(req_t w);
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        logic [XLEN-1:0]   imm;
        logic [XLEN-1:0]   val;
        logic [REG_AW-1:0] dst;
        logic              ok;
        rsp_t              r;
        a   = gpr_shadow[w.source_reg];
        b   = gpr_shadow[w.second_reg];
        imm = {{(XLEN-IMM_W){w.immediate[IMM_W-1]}}, w.immediate};
        val = '0;
        ok  = 1'b1;
        if (w.kind == OP_RTYPE)
        begin
            dst = w.dest_reg;
            case (w.function_code)
                FN_ADD, FN_ADDU: val = a + b;
                FN_SUB, FN_SUBU: val = a - b;
                FN_AND:          val = a & b;
                FN_OR:           val = a | b;
                FN_XOR:          val = a ^ b;
                FN_SLL:          val = b << w.shift_amount;
                FN_SRL:          val = b >> w.shift_amount;
                FN_SRA:          val = $signed(b) >>> w.shift_amount;
                FN_SLLV:         val = b << a[4:0];
                FN_SRLV:         val = b >> a[4:0];
                FN_SLT:          val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                FN_SLTU:         val = (a < b) ? 32'd1 : 32'd0;
                default:         ok = 1'b0;
            endcase
        end
        else
        begin
            dst = w.second_reg;
            case (w.kind)
                OP_ADDI, OP_ADDIU: val = a + imm;
                OP_SLTI:           val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
                OP_SLTIU:          val = (a < imm) ? 32'd1 : 32'd0;
                default:           ok = 1'b0;
            endcase
        end
        r = '0;
        if (ok)
        begin
            r.wrote         = 1'b1;
            r.written_reg   = dst;
            r.written_value = val;
        end
        else
        begin
            r.unsupported = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(string field, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            foreach (gpr_shadow[i])
                gpr_shadow[i] = '0;
            expected_writebacks.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                want = execute_alu(req);
                expected_writebacks.push_back(want);
                // register zero stays zero
                if (want.wrote && want.written_reg != '0)
                    gpr_shadow[want.written_reg] = want.written_value;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_writebacks.size() == 0)
                begin
                    $display("%0t: unexpected word expected none actual %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_writebacks.pop_front();
                    compare_field("wrote", XLEN'(want.wrote), XLEN'(rsp.wrote));
                    compare_field("written_reg", XLEN'(want.written_reg),
                                  XLEN'(rsp.written_reg));
                    compare_field("written_value", want.written_value, rsp.written_value);
                    compare_field("unsupported", XLEN'(want.unsupported),
                                  XLEN'(rsp.unsupported));
                end
            end
        end
        outstanding = expected_writebacks.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import malu_pkg::*;

    localparam int RANDOM_WORDS = 1300;
    localparam int CALM_WORDS   = 200;

    localparam logic [5:0] OP_UNUSED_TOP = 6'h3f;
    localparam logic [5:0] OP_UNUSED_LOW = 6'h02;
    localparam logic [5:0] FN_UNUSED_TOP = 6'h3f;
    localparam logic [5:0] FN_UNUSED_LOW = 6'h01;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;
    bit   calm      = 1'b0;

    funct_t     valid_functs [14] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_ADD,
                                      FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
                                      FN_SLT, FN_SLTU};
    opcode_t    imm_ops [4]       = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU};
    logic [15:0] corner_imms [4]  = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff};

    always #4 clk = ~clk;

    mips_alu_register_execute uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    malu_writeback_checker wb_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic req_t r_word(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs,
                                    logic [4:0] rt, logic [4:0] sh);
        req_t w;
        w               = '0;
        w.kind          = OP_RTYPE;
        w.function_code = fn;
        w.dest_reg      = rd;
        w.source_reg    = rs;
        w.second_reg    = rt;
        w.shift_amount  = sh;
        return w;
    endfunction

    function automatic req_t i_word(logic [5:0] op, logic [4:0] rt, logic [4:0] rs,
                                    logic [15:0] imm);
        req_t w;
        w            = '0;
        w.kind       = op;
        w.second_reg = rt;
        w.source_reg = rs;
        w.immediate  = imm;
        return w;
    endfunction

    // low registers favored so results feed later words
    function automatic logic [4:0] pick_reg();
        return 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 7));
    endfunction

    function automatic req_t random_word();
        req_t        w;
        int unsigned sel;
        w.source_reg    = pick_reg();
        w.second_reg    = pick_reg();
        w.dest_reg      = pick_reg();
        w.shift_amount  = 5'($urandom_range(0, 31));
        w.function_code = 6'($urandom_range(0, 63));
        w.immediate     = ($urandom_range(0, 7) == 0) ? corner_imms[$urandom_range(0, 3)]
                                                       : 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            w.kind = 6'($urandom_range(0, 63));
        end
        else if (sel == 1)
        begin
            w.kind = OP_RTYPE;
        end
        else if (sel < 13)
        begin
            w.kind          = OP_RTYPE;
            w.function_code = valid_functs[$urandom_range(0, 13)];
        end
        else
        begin
            w.kind = imm_ops[$urandom_range(0, 3)];
        end
        return w;
    endfunction

    task automatic send_word(req_t w);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    initial
    begin
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    initial
    begin
        int gap_pct;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // build corner values, then every operation back to back, then unsupported codes
        send_word(i_word(OP_ADDI, 1, 0, 16'h7fff));
        send_word(i_word(OP_ADDIU, 2, 0, 16'h8000));
        send_word(i_word(OP_ADDI, 3, 0, 16'hffff));
        send_word(r_word(FN_SLL, 4, 0, 3, 31));
        send_word(r_word(FN_SRL, 5, 0, 3, 1));
        send_word(i_word(OP_SLTI, 7, 2, 16'h0000));
        send_word(i_word(OP_SLTIU, 8, 2, 16'h0000));
        send_word(r_word(FN_ADD, 6, 5, 7, 0));
        send_word(r_word(FN_ADDU, 9, 3, 7, 0));
        send_word(r_word(FN_SUB, 10, 4, 7, 0));
        send_word(r_word(FN_SUBU, 11, 0, 7, 0));
        send_word(r_word(FN_AND, 12, 3, 2, 0));
        send_word(r_word(FN_OR, 13, 1, 4, 0));
        send_word(r_word(FN_XOR, 14, 3, 1, 0));
        send_word(r_word(FN_SRA, 15, 0, 4, 31));
        send_word(r_word(FN_SLLV, 16, 3, 7, 0));
        send_word(r_word(FN_SRLV, 17, 3, 4, 0));
        send_word(r_word(FN_SLT, 18, 4, 5, 0));
        send_word(r_word(FN_SLTU, 19, 4, 5, 0));
        send_word(r_word(FN_ADD, 0, 3, 3, 0));
        send_word(r_word(FN_OR, 20, 0, 0, 0));
        send_word(i_word(OP_SLTIU, 21, 0, 16'hffff));
        send_word(i_word(OP_SLTI, 22, 0, 16'h8000));
        send_word(i_word(OP_UNUSED_TOP, 23, 3, 16'h1234));
        send_word(i_word(OP_UNUSED_LOW, 24, 3, 16'h0001));
        send_word(r_word(FN_UNUSED_TOP, 25, 3, 3, 0));
        send_word(r_word(FN_UNUSED_LOW, 26, 3, 3, 0));

        gap_pct = 0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= RANDOM_WORDS - CALM_WORDS);
            if (i % 64 == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            if (!calm && $urandom_range(0, 99) < gap_pct)
                pause_sender($urandom_range(1, 12));
            send_word(random_word());
        end
        req_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("mips_alu_register_execute regression: pass");
        else
            $display("mips_alu_register_execute regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("mips_alu_register_execute regression: fail");
        $finish;
    end

endmodule
